[rtl/rotated_chunk_candidate_generator_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ROTATED_CHUNK_CANDIDATE_GENERATOR_MACROS_SVH
`define ROTATED_CHUNK_CANDIDATE_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCG_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcg assertion failed");

`endif

[rtl/rcg_pkg.sv]
`default_nettype none
package rcg_pkg;

	localparam int MaxWord = 256;
	localparam int AddrW = $clog2(MaxWord);
	localparam int LenW = AddrW + 1;
	localparam int MaxChunk = 4;
	localparam int SizeW = 3;
	localparam int StepW = $clog2(MaxChunk);
	localparam int ByteW = 8;
	localparam int ChunkW = 32;
	localparam int QueueDepth = 2;
	localparam int QPtrW = $clog2(QueueDepth);
	localparam int QCntW = $clog2(QueueDepth + 1);

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_END = 2'd1;
	localparam logic [1:0] OP_PULL = 2'd2;

	typedef enum logic [1:0] {
		CMD_APPEND,
		CMD_END,
		CMD_PULL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [ByteW-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t entry;
	} queue_link_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CAPTURE,
		BK_RESULT
	} back_state_t;

	typedef struct packed {
		logic valid_res;
		logic [ChunkW-1:0] chunk_bytes;
		logic [2:0] chunk_len;
		logic done_res;
		logic overflow;
	} result_t;

endpackage
`default_nettype wire

[rtl/rcg_if.sv]
`default_nettype none
interface rcg_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [rcg_pkg::ByteW-1:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface rcg_res_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic [rcg_pkg::ChunkW-1:0] chunk_bytes;
	logic [2:0] chunk_len;
	logic done_res;
	logic overflow;

	modport source (output valid, output valid_res, output chunk_bytes, output chunk_len,
		output done_res, output overflow, input ready);
	modport sink (input valid, input valid_res, input chunk_bytes, input chunk_len,
		input done_res, input overflow, output ready);
endinterface
`default_nettype wire

[rtl/rotated_chunk_candidate_generator.sv]
// The cmd channel takes one word per handshake: an op code and a data byte. Op 0 appends
// the byte to the current word, op 1 closes the word and starts the candidate list, op 2
// pulls the next candidate and op 3 is dropped. Only pulls give a word on the res channel:
// a chunk of one to four bytes with its length, or a done flag once the list is used up,
// together with the overflow flag of a word that was cut to 256 bytes.
// A two-entry queue sits between the input handshake and the sequencer, so cmd keeps
// accepting while a result waits in the output register.
// Appends and end marks are taken in the idle state of the sequencer. A pull that yields a
// chunk reads the word memory through its single read port, one byte at a time in a read
// state and a capture state, and then loads the result in the result state; a pull that
// answers done goes straight to the result state.
// While the receiver holds res.ready low the result stays in the output register, the
// sequencer waits with the next pull, and cmd stalls once the queue is full.
// Reset clears the word length, the flags and the candidate cursor; the word memory is
// not cleared, as only bytes of the current word are ever read.
`default_nettype none
module rotated_chunk_candidate_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	rcg_cmd_if.sink cmd,
	rcg_res_if.source res
);

	rcg_pkg::queue_link_t q;
	logic q_pop;

	rcg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q      (q),
		.q_pop  (q_pop)
	);

	rcg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.q_pop  (q_pop),
		.res    (res)
	);

endmodule
`default_nettype wire

[rtl/rcg_front.sv]
`default_nettype none
module rcg_front (
	input  wire logic clk,
	input  wire logic arst_n,
	rcg_cmd_if.sink cmd,
	output rcg_pkg::queue_link_t q,
	input  wire logic q_pop
);

	rcg_pkg::cmd_t entry_q [rcg_pkg::QueueDepth];
	logic [rcg_pkg::QPtrW-1:0] wr_ptr_q;
	logic [rcg_pkg::QPtrW-1:0] rd_ptr_q;
	logic [rcg_pkg::QCntW-1:0] count_q;
	logic keep;
	logic push;
	logic pop;
	rcg_pkg::cmd_t incoming;

	always_comb begin
		keep = 1'b1;
		incoming.data = cmd.data_byte;
		case (cmd.op)
			rcg_pkg::OP_APPEND: incoming.kind = rcg_pkg::CMD_APPEND;
			rcg_pkg::OP_END: incoming.kind = rcg_pkg::CMD_END;
			rcg_pkg::OP_PULL: incoming.kind = rcg_pkg::CMD_PULL;
			default: begin
				incoming.kind = rcg_pkg::CMD_PULL;
				keep = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (count_q != rcg_pkg::QCntW'(rcg_pkg::QueueDepth));
	assign push = cmd.valid && cmd.ready && keep;
	assign q.valid = (count_q != '0);
	assign q.entry = entry_q[rd_ptr_q];
	assign pop = q_pop && q.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rcg_back.sv]
`default_nettype none
module rcg_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rcg_pkg::queue_link_t q,
	output logic q_pop,
	rcg_res_if.source res
);

	localparam int AddrW = rcg_pkg::AddrW;
	localparam int LenW = rcg_pkg::LenW;
	localparam int SizeW = rcg_pkg::SizeW;
	localparam int StepW = rcg_pkg::StepW;
	localparam int ByteW = rcg_pkg::ByteW;

	logic [ByteW-1:0] mem [rcg_pkg::MaxWord];
	logic [ByteW-1:0] rd_data_q;

	rcg_pkg::back_state_t state_q, state_d;
	logic [LenW-1:0] len_q, len_d;
	logic cut_q, cut_d;
	logic gen_q, gen_d;
	logic [SizeW-1:0] size_q, size_d;
	logic right_q, right_d;
	logic [StepW-1:0] step_q, step_d;
	logic [SizeW-1:0] off_q, off_d;
	logic [LenW-1:0] pos_q, pos_d;
	logic cand_q, cand_d;
	logic [AddrW-1:0] idx_q, idx_d;
	logic [StepW-1:0] k_q, k_d;
	logic [rcg_pkg::ChunkW-1:0] acc_q, acc_d;
	rcg_pkg::result_t out_q;
	logic out_valid_q;

	logic mem_we;
	logic [AddrW-1:0] mem_wa;
	logic rd_en;
	logic load_out;
	logic [SizeW-1:0] limit;
	logic [LenW:0] start_sum;
	logic [AddrW-1:0] start_idx;
	logic [LenW-1:0] idx_inc;
	logic [LenW-1:0] pos_next;
	logic [LenW:0] pos_end;
	logic [StepW:0] step_next;
	rcg_pkg::result_t out_d;

	assign limit = (len_q >= LenW'(rcg_pkg::MaxChunk)) ? SizeW'(rcg_pkg::MaxChunk)
		: SizeW'(len_q);
	assign start_sum = {1'b0, pos_q} + (LenW + 1)'(off_q);
	assign start_idx = (start_sum >= {1'b0, len_q}) ? AddrW'(start_sum - {1'b0, len_q})
		: AddrW'(start_sum);
	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign pos_next = pos_q + LenW'(size_q);
	assign pos_end = {1'b0, pos_next} + (LenW + 1)'(size_q);
	assign step_next = {1'b0, step_q} + 1'b1;

	always_comb begin
		state_d = state_q;
		len_d = len_q;
		cut_d = cut_q;
		gen_d = gen_q;
		size_d = size_q;
		right_d = right_q;
		step_d = step_q;
		off_d = off_q;
		pos_d = pos_q;
		cand_d = cand_q;
		idx_d = idx_q;
		k_d = k_q;
		acc_d = acc_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		mem_wa = AddrW'(len_q);
		rd_en = 1'b0;
		load_out = 1'b0;
		out_d.valid_res = cand_q;
		out_d.chunk_bytes = cand_q ? acc_q : '0;
		out_d.chunk_len = cand_q ? 3'(size_q) : 3'd0;
		out_d.done_res = !cand_q;
		out_d.overflow = cut_q;
		case (state_q)
			rcg_pkg::BK_IDLE: begin
				if (q.valid) begin
					q_pop = 1'b1;
					case (q.entry.kind)
						rcg_pkg::CMD_APPEND: begin
							if (gen_q) begin
								gen_d = 1'b0;
								cut_d = 1'b0;
								len_d = LenW'(1);
								mem_we = 1'b1;
								mem_wa = '0;
								size_d = SizeW'(1);
								right_d = 1'b0;
								step_d = '0;
								off_d = '0;
								pos_d = '0;
							end else if (len_q < LenW'(rcg_pkg::MaxWord)) begin
								mem_we = 1'b1;
								len_d = len_q + 1'b1;
							end else begin
								cut_d = 1'b1;
							end
						end
						rcg_pkg::CMD_END: begin
							gen_d = 1'b1;
							size_d = SizeW'(1);
							right_d = 1'b0;
							step_d = '0;
							off_d = '0;
							pos_d = '0;
						end
						default: begin
							if (!gen_q || len_q == '0 || size_q > limit) begin
								cand_d = 1'b0;
								state_d = rcg_pkg::BK_RESULT;
							end else begin
								cand_d = 1'b1;
								idx_d = start_idx;
								k_d = '0;
								acc_d = '0;
								state_d = rcg_pkg::BK_READ;
							end
						end
					endcase
				end
			end
			rcg_pkg::BK_READ: begin
				rd_en = 1'b1;
				state_d = rcg_pkg::BK_CAPTURE;
			end
			rcg_pkg::BK_CAPTURE: begin
				acc_d[k_q*ByteW +: ByteW] = rd_data_q;
				if ((SizeW'(k_q) + 1'b1) == size_q) begin
					state_d = rcg_pkg::BK_RESULT;
				end else begin
					k_d = k_q + 1'b1;
					idx_d = (idx_inc == len_q) ? '0 : AddrW'(idx_inc);
					state_d = rcg_pkg::BK_READ;
				end
			end
			rcg_pkg::BK_RESULT: begin
				if (!out_valid_q || res.ready) begin
					load_out = 1'b1;
					state_d = rcg_pkg::BK_IDLE;
					if (cand_q) begin
						if (pos_end <= {1'b0, len_q}) begin
							pos_d = pos_next;
						end else begin
							pos_d = '0;
							if (step_next < (StepW + 1)'(size_q)) begin
								step_d = StepW'(step_next);
								off_d = right_q ? off_q - 1'b1 : off_q + 1'b1;
							end else begin
								step_d = '0;
								if (!right_q) begin
									right_d = 1'b1;
									off_d = size_q;
								end else begin
									right_d = 1'b0;
									size_d = size_q + 1'b1;
									off_d = '0;
								end
							end
						end
					end
				end
			end
			default: begin
				state_d = rcg_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= q.entry.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		k_q <= k_d;
		acc_q <= acc_d;
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcg_pkg::BK_IDLE;
			len_q <= '0;
			cut_q <= 1'b0;
			gen_q <= 1'b0;
			size_q <= SizeW'(1);
			right_q <= 1'b0;
			step_q <= '0;
			off_q <= '0;
			pos_q <= '0;
			cand_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			cut_q <= cut_d;
			gen_q <= gen_d;
			size_q <= size_d;
			right_q <= right_d;
			step_q <= step_d;
			off_q <= off_d;
			pos_q <= pos_d;
			cand_q <= cand_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.valid_res = out_q.valid_res;
	assign res.chunk_bytes = out_q.chunk_bytes;
	assign res.chunk_len = out_q.chunk_len;
	assign res.done_res = out_q.done_res;
	assign res.overflow = out_q.overflow;

endmodule
`default_nettype wire

[rtl/rcg_checker.sv]
`default_nettype none
`include "rotated_chunk_candidate_generator_macros.svh"
module rcg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic valid_res,
	input wire logic [31:0] chunk_bytes,
	input wire logic [2:0] chunk_len,
	input wire logic done_res
);

	`RCG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(chunk_bytes) && $stable(chunk_len) && $stable(done_res))
	`RCG_ASSERT_SAME(a_chunk_or_done, res_valid, valid_res != done_res)
	`RCG_ASSERT_SAME(a_chunk_len, res_valid && valid_res, chunk_len != 3'd0 && chunk_len <= 3'd4)
	`RCG_ASSERT_SAME(a_done_empty, res_valid && done_res, chunk_bytes == 32'd0 && chunk_len == 3'd0)

endmodule

bind rotated_chunk_candidate_generator rcg_checker u_rcg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.valid_res   (res.valid_res),
	.chunk_bytes (res.chunk_bytes),
	.chunk_len   (res.chunk_len),
	.done_res    (res.done_res)
);
`default_nettype wire
